[sv/modbus_rtu_request_framer_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Modbus RTU request framer
// Clocked concurrent assertions, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_REQUEST_FRAMER_MACROS_SVH
`define MODBUS_RTU_REQUEST_FRAMER_MACROS_SVH

`ifndef ASSERT_OFF
// checked only out of reset
`define MRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked during reset as well
`define MRF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MRF_ASSERT(lbl, prop, msg)
`define MRF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[sv/mrf_pkg.sv]
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared codes, constants and types of the Modbus RTU request framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrf_pkg;

  // request operations
  localparam logic [1:0] OP_READ_HOLDING = 2'd0;
  localparam logic [1:0] OP_WRITE_SINGLE = 2'd1;
  localparam logic [1:0] OP_WRITE_MULTI  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_SLAVE   = 2'd0;
  localparam logic [1:0] CFG_MAX_SLAVE   = 2'd1;
  localparam logic [1:0] CFG_READ_LIMIT  = 2'd2;
  localparam logic [1:0] CFG_WRITE_LIMIT = 2'd3;

  localparam logic [7:0] MIN_SLAVE_RESET   = 8'd1;
  localparam logic [7:0] MAX_SLAVE_RESET   = 8'd247;
  localparam logic [6:0] READ_LIMIT_RESET  = 7'd125;
  localparam logic [6:0] WRITE_LIMIT_RESET = 7'd123;

  // function codes on the wire
  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'd6;
  localparam logic [7:0] FC_WRITE_MULTI  = 8'd16;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // job kinds handed from front to back
  localparam logic [2:0] KIND_ERROR  = 3'd0;
  localparam logic [2:0] KIND_READ   = 3'd1;
  localparam logic [2:0] KIND_SINGLE = 3'd2;
  localparam logic [2:0] KIND_MULTI  = 3'd3;
  localparam logic [2:0] KIND_WORD   = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic        last;      // append CRC after the data bytes
    logic [7:0]  slave;
    logic [15:0] reg_addr;
    logic [15:0] qty;
    logic [15:0] data;
  } job_t;

  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic       request_error;
  } out_item_t;

endpackage

`default_nettype wire

[sv/modbus_rtu_request_framer.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer
// Frames Modbus RTU requests (functions 3, 6, 16) as a byte stream with a
// CRC-16 appended high byte first.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | in_push / in_full  | operation, slave, register, count, data word
//  result   | out_pop / out_empty| out_byte, frame_end, request_error
//  config   | cfg_we             | cfg_index, cfg_wdata
//
//  Each item yields 1 to 11 result bytes, sent at one byte a cycle by the
//  serialiser unless stalled; a write-multiple header with one word yields
//  11, a read or write-single 8, a rejected request 1. A two-entry job queue
//  lets the front take items while the serialiser works. A stall on out_pop
//  backs up the output queue, then the job queue, then raises in_full. Reset
//  clears the queues and the open run and restores the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "modbus_rtu_request_framer_macros.svh"

module modbus_rtu_request_framer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_slave_address,
  input  wire logic [15:0] in_register_address,
  input  wire logic [15:0] in_word_count,
  input  wire logic [15:0] in_data_word,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_byte,
  output logic             out_frame_end,
  output logic             out_request_error
);
  import mrf_pkg::*;

  job_t front_job, head_job;
  logic job_push, job_pop, job_valid, jq_full;

  assign in_full  = jq_full;
  assign job_push = in_push && !jq_full;

  mrf_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .accept              (job_push),
    .in_operation        (in_operation),
    .in_slave_address    (in_slave_address),
    .in_register_address (in_register_address),
    .in_word_count       (in_word_count),
    .in_data_word        (in_data_word),
    .job                 (front_job)
  );

  mrf_job_queue u_job_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (front_job),
    .pop      (job_pop),
    .valid    (job_valid),
    .full     (jq_full),
    .head     (head_job)
  );

  mrf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_valid         (job_valid),
    .job               (head_job),
    .job_pop           (job_pop),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_byte          (out_byte),
    .out_frame_end     (out_frame_end),
    .out_request_error (out_request_error)
  );

  `MRF_ASSERT_ALWAYS(a_empty_after_reset, !rst_n |=> out_empty, "results present after reset")
  `MRF_ASSERT(a_pop_needs_job, job_pop |-> job_valid, "job retired from an empty queue")
  `MRF_ASSERT(a_push_keeps_job, (job_push && !job_pop) |=> job_valid, "queued job lost")
  `MRF_ASSERT(a_error_ends_frame,
    (!out_empty && out_request_error) |-> (out_frame_end && out_byte == 8'd0),
    "error result without frame end or with nonzero byte")

endmodule

`default_nettype wire

[sv/mrf_front.sv]
// ----------------------------------------------------------------------------
// mrf_front
// Holds configuration, validates requests, tracks open write-multiple runs
// and turns each accepted item into a job for the serialiser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrf_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [7:0]        cfg_wdata,
  input  wire logic              accept,
  input  wire logic [1:0]        in_operation,
  input  wire logic [7:0]        in_slave_address,
  input  wire logic [15:0]       in_register_address,
  input  wire logic [15:0]       in_word_count,
  input  wire logic [15:0]       in_data_word,
  output mrf_pkg::job_t          job
);
  import mrf_pkg::*;

  logic [7:0]  min_slave_r, max_slave_r;
  logic [6:0]  read_limit_r, write_limit_r;
  logic [6:0]  words_left_r, words_left_nxt;

  logic        slave_ok, qty_nz, read_qty_ok, write_qty_ok, span_ok;
  logic [16:0] span_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_slave_r   <= MIN_SLAVE_RESET;
      max_slave_r   <= MAX_SLAVE_RESET;
      read_limit_r  <= READ_LIMIT_RESET;
      write_limit_r <= WRITE_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_SLAVE:   min_slave_r   <= cfg_wdata;
        CFG_MAX_SLAVE:   max_slave_r   <= cfg_wdata;
        CFG_READ_LIMIT:  read_limit_r  <= cfg_wdata[6:0];
        CFG_WRITE_LIMIT: write_limit_r <= cfg_wdata[6:0];
      endcase
    end
  end

  always_comb begin
    slave_ok     = (in_slave_address >= min_slave_r) && (in_slave_address <= max_slave_r);
    qty_nz       = (in_word_count != 16'd0);
    read_qty_ok  = qty_nz && (in_word_count <= {9'd0, read_limit_r});
    write_qty_ok = qty_nz && (in_word_count <= {9'd0, write_limit_r});
    // last register of the span must not pass the top of the map
    span_end     = {1'b0, in_register_address} + {1'b0, in_word_count} - 17'd1;
    span_ok      = !span_end[16];

    job.slave    = in_slave_address;
    job.reg_addr = in_register_address;
    job.qty      = in_word_count;
    job.data     = in_data_word;
    job.kind     = KIND_ERROR;
    job.last     = 1'b1;
    words_left_nxt = words_left_r;

    if (words_left_r != 7'd0) begin
      job.kind       = KIND_WORD;
      job.last       = (words_left_r == 7'd1);
      words_left_nxt = words_left_r - 7'd1;
    end else begin
      unique case (in_operation)
        OP_READ_HOLDING: begin
          if (slave_ok && read_qty_ok && span_ok) job.kind = KIND_READ;
        end
        OP_WRITE_SINGLE: begin
          if (slave_ok) job.kind = KIND_SINGLE;
        end
        OP_WRITE_MULTI: begin
          if (slave_ok && write_qty_ok && span_ok) begin
            job.kind = KIND_MULTI;
            job.last = (in_word_count == 16'd1);
            // quantity is at most the 7-bit limit here
            words_left_nxt = in_word_count[6:0] - 7'd1;
          end
        end
        default: job.kind = KIND_ERROR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_left_r <= 7'd0;
    end else if (accept) begin
      words_left_r <= words_left_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/mrf_job_queue.sv]
// ----------------------------------------------------------------------------
// mrf_job_queue
// Two-entry queue of jobs between the front and the serialiser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrf_job_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire mrf_pkg::job_t     push_job,
  input  wire logic              pop,
  output logic                   valid,
  output logic                   full,
  output mrf_pkg::job_t          head
);
  import mrf_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    valid     = (count_r != 2'd0);
    full      = (count_r == 2'd2);
    head      = mem_r[rd_ptr_r];
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/mrf_back.sv]
// ----------------------------------------------------------------------------
// mrf_back
// Serialises jobs into frame bytes, one a cycle while the output queue has
// room, keeps the running CRC and buffers results in a two-entry output queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrf_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_valid,
  input  wire mrf_pkg::job_t     job,
  output logic                   job_pop,
  input  wire logic              out_pop,
  output logic                   out_empty,
  output logic [7:0]             out_byte,
  output logic                   out_frame_end,
  output logic                   out_request_error
);
  import mrf_pkg::*;

  function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (v[0]) v = (v >> 1) ^ CRC_POLY;
      else      v = v >> 1;
    end
    return v;
  endfunction

  logic [3:0]  step_r, step_nxt;
  logic [15:0] crc_r, crc_nxt, crc_base;
  logic [3:0]  n_data, last_step;
  logic        has_crc, is_crc_hi, is_crc_lo, is_err, emit;
  logic [7:0]  data_byte, fc;
  out_item_t   item;

  out_item_t   oq_r [2];
  logic        oq_wr_r, oq_rd_r, oq_full, oq_pop;
  logic [1:0]  oq_count_r;

  always_comb begin
    is_err = (job.kind == KIND_ERROR);
    unique case (job.kind)
      KIND_READ, KIND_SINGLE: n_data = 4'd6;
      KIND_MULTI:             n_data = 4'd9;
      KIND_WORD:              n_data = 4'd2;
      default:                n_data = 4'd1;
    endcase
    has_crc   = !is_err && job.last;
    last_step = has_crc ? n_data + 4'd1 : n_data - 4'd1;
    is_crc_hi = has_crc && (step_r == n_data);
    is_crc_lo = has_crc && (step_r == n_data + 4'd1);

    unique case (job.kind)
      KIND_READ:   fc = FC_READ_HOLDING;
      KIND_SINGLE: fc = FC_WRITE_SINGLE;
      default:     fc = FC_WRITE_MULTI;
    endcase

    if (job.kind == KIND_WORD) begin
      data_byte = step_r[0] ? job.data[7:0] : job.data[15:8];
    end else begin
      unique case (step_r)
        4'd0:    data_byte = job.slave;
        4'd1:    data_byte = fc;
        4'd2:    data_byte = job.reg_addr[15:8];
        4'd3:    data_byte = job.reg_addr[7:0];
        4'd4:    data_byte = (job.kind == KIND_SINGLE) ? job.data[15:8] : job.qty[15:8];
        4'd5:    data_byte = (job.kind == KIND_SINGLE) ? job.data[7:0] : job.qty[7:0];
        4'd6:    data_byte = {job.qty[6:0], 1'b0};
        4'd7:    data_byte = job.data[15:8];
        4'd8:    data_byte = job.data[7:0];
        default: data_byte = 8'd0;
      endcase
    end

    priority if (is_crc_hi) item.data = crc_r[15:8];
    else if (is_crc_lo)     item.data = crc_r[7:0];
    else if (is_err)        item.data = 8'd0;
    else                    item.data = data_byte;
    item.frame_end     = is_crc_lo || is_err;
    item.request_error = is_err;

    emit    = job_valid && !oq_full;
    job_pop = emit && (step_r == last_step);

    // a request header always opens a fresh CRC
    crc_base = (step_r == 4'd0 && job.kind != KIND_WORD) ? CRC_INIT : crc_r;
    crc_nxt  = crc_r;
    if (emit) begin
      if (is_crc_lo)                    crc_nxt = CRC_INIT;
      else if (!is_crc_hi && !is_err)   crc_nxt = crc_update(crc_base, item.data);
    end

    step_nxt = step_r;
    if (emit) step_nxt = (step_r == last_step) ? 4'd0 : step_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 4'd0;
      crc_r  <= CRC_INIT;
    end else begin
      step_r <= step_nxt;
      crc_r  <= crc_nxt;
    end
  end

  // output queue
  always_comb begin
    oq_full           = (oq_count_r == 2'd2);
    out_empty         = (oq_count_r == 2'd0);
    oq_pop            = out_pop && !out_empty;
    out_byte          = oq_r[oq_rd_r].data;
    out_frame_end     = oq_r[oq_rd_r].frame_end;
    out_request_error = oq_r[oq_rd_r].request_error;
  end

  always_ff @(posedge clk) begin
    if (emit) oq_r[oq_wr_r] <= item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r    <= 1'b0;
      oq_rd_r    <= 1'b0;
      oq_count_r <= 2'd0;
    end else begin
      if (emit)   oq_wr_r <= ~oq_wr_r;
      if (oq_pop) oq_rd_r <= ~oq_rd_r;
      oq_count_r <= oq_count_r + {1'b0, emit} - {1'b0, oq_pop};
    end
  end

endmodule

`default_nettype wire

[sim/modbus_rtu_request_framer_tb.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer_tb
// Self-checking bench for the Modbus RTU request framer. A scoreboard class
// predicts the byte stream of every accepted item (frame bytes, CRC high byte
// first, reject bytes) and checks each popped byte in order. Directed items
// cover field extremes and the validation corners; random phases under
// several register settings mix well-formed requests and runs with noise,
// while the sender works in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modbus_rtu_request_framer_tb;
  import mrf_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         LIMIT_CYCLES = 400000;
  localparam int         SETTLE       = 24;
  localparam int         PHASE_ITEMS  = 50;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  slave;
    logic [15:0] reg_addr;
    logic [15:0] qty;
    logic [15:0] data;
  } request_t;

  class frame_scoreboard;
    logic [7:0]  min_slave;
    logic [7:0]  max_slave;
    logic [6:0]  read_limit;
    logic [6:0]  write_limit;
    logic [15:0] crc;
    logic [6:0]  words_left;
    out_item_t   bytes_due[$];
    int          mismatches;
    int          bytes_checked;
    int          frames;
    int          rejects;

    function new();
      min_slave   = MIN_SLAVE_RESET;
      max_slave   = MAX_SLAVE_RESET;
      read_limit  = READ_LIMIT_RESET;
      write_limit = WRITE_LIMIT_RESET;
      crc         = CRC_INIT;
      words_left  = '0;
      mismatches  = 0;
      bytes_checked = 0;
      frames      = 0;
      rejects     = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_MIN_SLAVE:   min_slave = val;
        CFG_MAX_SLAVE:   max_slave = val;
        CFG_READ_LIMIT:  read_limit = val[6:0];
        CFG_WRITE_LIMIT: write_limit = val[6:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return bytes_due.size();
    endfunction

    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      c = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
    endfunction

    function void add_raw(logic [7:0] b, logic fe, logic err);
      out_item_t it;
      it.data          = b;
      it.frame_end     = fe;
      it.request_error = err;
      bytes_due.push_back(it);
    endfunction

    function void add_byte(logic [7:0] b);
      crc = crc_step(crc, b);
      add_raw(b, 1'b0, 1'b0);
    endfunction

    function void add_word(logic [15:0] w);
      add_byte(w[15:8]);
      add_byte(w[7:0]);
    endfunction

    // CRC goes out high byte first and is not folded into itself
    function void close_frame();
      add_raw(crc[15:8], 1'b0, 1'b0);
      add_raw(crc[7:0], 1'b1, 1'b0);
      crc = CRC_INIT;
      frames++;
    endfunction

    function logic qty_ok(logic [15:0] reg_addr, logic [15:0] qty, logic [6:0] lim);
      if (qty == 16'd0 || qty > {9'd0, lim}) return 1'b0;
      return ({16'd0, reg_addr} + {16'd0, qty} - 32'd1) <= 32'h0000_FFFF;
    endfunction

    function void note_input(request_t r);
      logic       ok;
      logic       slave_in;
      logic [7:0] fc;
      if (words_left != 0) begin
        // open run: only the data word counts
        add_word(r.data);
        words_left = words_left - 7'd1;
        if (words_left == 0) close_frame();
        return;
      end
      slave_in = (r.slave >= min_slave) && (r.slave <= max_slave);
      case (r.op)
        OP_READ_HOLDING: ok = slave_in && qty_ok(r.reg_addr, r.qty, read_limit);
        OP_WRITE_SINGLE: ok = slave_in;
        OP_WRITE_MULTI:  ok = slave_in && qty_ok(r.reg_addr, r.qty, write_limit);
        default:         ok = 1'b0;
      endcase
      if (!ok) begin
        add_raw(8'h00, 1'b1, 1'b1);
        rejects++;
        return;
      end
      case (r.op)
        OP_READ_HOLDING: fc = FC_READ_HOLDING;
        OP_WRITE_SINGLE: fc = FC_WRITE_SINGLE;
        default:         fc = FC_WRITE_MULTI;
      endcase
      crc = CRC_INIT;
      add_byte(r.slave);
      add_byte(fc);
      add_word(r.reg_addr);
      if (r.op == OP_WRITE_SINGLE) begin
        add_word(r.data);
        close_frame();
        return;
      end
      add_word(r.qty);
      if (r.op == OP_READ_HOLDING) begin
        close_frame();
        return;
      end
      add_byte({r.qty[6:0], 1'b0});
      add_word(r.data);
      if (r.qty == 16'd1) close_frame();
      else words_left = r.qty[6:0] - 7'd1;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (bytes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected byte %02h end %0b err %0b with nothing due",
                   got.data, got.frame_end, got.request_error);
        return;
      end
      want = bytes_due.pop_front();
      bytes_checked++;
      if (got.data !== want.data || got.frame_end !== want.frame_end ||
          got.request_error !== want.request_error) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: byte %0d expected %02h end %0b err %0b, got %02h end %0b err %0b",
                   bytes_checked, want.data, want.frame_end, want.request_error,
                   got.data, got.frame_end, got.request_error);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_wdata = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_operation = '0;
  logic [7:0]  in_slave_address = '0;
  logic [15:0] in_register_address = '0;
  logic [15:0] in_word_count = '0;
  logic [15:0] in_data_word = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [7:0]  out_byte;
  logic        out_frame_end;
  logic        out_request_error;

  frame_scoreboard sb;
  int          items_sent = 0;
  int          burst_left = 0;
  int          phases = 0;
  int          cycle_count = 0;
  int          rx_mode = 0;
  int          pop_hold = 0;

  modbus_rtu_request_framer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_operation       (in_operation),
    .in_slave_address   (in_slave_address),
    .in_register_address(in_register_address),
    .in_word_count      (in_word_count),
    .in_data_word       (in_data_word),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_byte           (out_byte),
    .out_frame_end      (out_frame_end),
    .out_request_error  (out_request_error)
  );

  always #1 clk = ~clk;

  // receiver: a randomly chosen mode of free flow, coin flips or long holds
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop  <= 1'b0;
      pop_hold <= 0;
    end else if (pop_hold != 0) begin
      pop_hold <= pop_hold - 1;
    end else begin
      case (rx_mode)
        0: out_pop <= 1'b1;
        1: out_pop <= 1'($urandom_range(0, 1));
        default: begin
          out_pop  <= ~out_pop;
          pop_hold <= $urandom_range(0, 15);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (cycle_count % 100 == 0) rx_mode <= $urandom_range(0, 2);
  end

  always @(posedge clk) begin
    out_item_t got;
    if (rst_n && out_pop && !out_empty) begin
      got.data          = out_byte;
      got.frame_end     = out_frame_end;
      got.request_error = out_request_error;
      sb.check_result(got);
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // hold the item until the edge that takes it; in_push stays high on return
  task automatic push_item(request_t r);
    in_push             <= 1'b1;
    in_operation        <= r.op;
    in_slave_address    <= r.slave;
    in_register_address <= r.reg_addr;
    in_word_count       <= r.qty;
    in_data_word        <= r.data;
    do @(posedge clk); while (in_full);
    sb.note_input(r);
    items_sent++;
  endtask

  task automatic send_paced(request_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 9);
      if (gap != 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 16);
    end
    burst_left--;
    push_item(r);
  endtask

  function automatic request_t mk_req(logic [1:0] op, logic [7:0] slave,
                                      logic [15:0] reg_addr, logic [15:0] qty,
                                      logic [15:0] data);
    request_t r;
    r.op       = op;
    r.slave    = slave;
    r.reg_addr = reg_addr;
    r.qty      = qty;
    r.data     = data;
    return r;
  endfunction

  function automatic request_t noise_req();
    return mk_req(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
  endfunction

  task automatic wait_idle();
    in_push <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic close_run();
    while (sb.words_left != 0) send_paced(noise_req());
  endtask

  task automatic write_registers(logic [7:0] lo, logic [7:0] hi,
                                 logic [6:0] rd, logic [6:0] wr);
    logic [1:0] idx [4];
    logic [7:0] val [4];
    idx = '{CFG_MIN_SLAVE, CFG_MAX_SLAVE, CFG_READ_LIMIT, CFG_WRITE_LIMIT};
    val = '{lo, hi, {1'b0, rd}, {1'b0, wr}};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.set_register(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    phases++;
  endtask

  task automatic send_random_sequence();
    request_t   r;
    logic [6:0] lim;
    logic       clean;
    clean = ($urandom_range(0, 9) < 7);
    r = noise_req();
    if (r.op == OP_UNUSED && clean) r.op = 2'($urandom_range(0, 2));
    lim = (r.op == OP_READ_HOLDING) ? sb.read_limit : sb.write_limit;
    if (clean) begin
      case ($urandom_range(0, 7))
        0: r.slave = sb.min_slave;
        1: r.slave = sb.max_slave;
        default: r.slave = 8'($urandom_range(sb.min_slave, sb.max_slave));
      endcase
      if (lim == 0) r.qty = 16'($urandom_range(0, 2));
      else if ($urandom_range(0, 29) == 0) r.qty = {9'd0, lim};
      else r.qty = 16'($urandom_range(1, (lim < 6) ? lim : 6));
      if ($urandom_range(0, 5) == 0) r.reg_addr = 16'(32'h10000 - r.qty);
      else if ({16'd0, r.reg_addr} + r.qty > 32'h10000 && $urandom_range(0, 3) != 0)
        r.reg_addr = r.reg_addr >> 1;
    end else begin
      case ($urandom_range(0, 3))
        0: ;
        1: r.qty = 16'd0;
        2: r.qty = {9'd0, lim} + 16'd1;
        default: r.qty = 16'($urandom_range(1, 8));
      endcase
    end
    send_paced(r);
    // finish a well-formed run; after noise the run may stay open
    if (clean) close_run();
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners at the reset register values
    send_paced(mk_req(OP_READ_HOLDING, 8'd1,   16'h0000, 16'd1,    16'h0000));
    send_paced(mk_req(OP_READ_HOLDING, 8'd247, 16'hFFFF, 16'd1,    16'h0000));
    send_paced(mk_req(OP_READ_HOLDING, 8'd247, 16'hFFFF, 16'd2,    16'h0000));
    send_paced(mk_req(OP_READ_HOLDING, 8'd1,   16'h0000, 16'd0,    16'h0000));
    send_paced(mk_req(OP_READ_HOLDING, 8'd10,  16'h1234, 16'd125,  16'h0000));
    send_paced(mk_req(OP_READ_HOLDING, 8'd10,  16'h0000, 16'd126,  16'h0000));
    send_paced(mk_req(OP_READ_HOLDING, 8'd10,  16'hFF83, 16'd125,  16'h0000));
    send_paced(mk_req(OP_READ_HOLDING, 8'd10,  16'h0000, 16'hFFFF, 16'h0000));
    send_paced(mk_req(OP_WRITE_SINGLE, 8'd0,   16'h0001, 16'd0,    16'h1234));
    send_paced(mk_req(OP_WRITE_SINGLE, 8'd248, 16'h0001, 16'd0,    16'h1234));
    send_paced(mk_req(OP_WRITE_SINGLE, 8'd247, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_paced(mk_req(OP_WRITE_SINGLE, 8'd1,   16'h0000, 16'd0,    16'h0000));
    send_paced(mk_req(OP_UNUSED,       8'd5,   16'h0010, 16'd1,    16'h0000));
    send_paced(mk_req(OP_WRITE_MULTI,  8'd1,   16'h0100, 16'd1,    16'hA5A5));
    send_paced(mk_req(OP_WRITE_MULTI,  8'h11,  16'h0200, 16'd3,    16'h1111));
    // run words: every other field is ignored
    send_paced(mk_req(OP_UNUSED,       8'hFF,  16'hFFFF, 16'hFFFF, 16'h2222));
    send_paced(mk_req(OP_READ_HOLDING, 8'd0,   16'h0000, 16'd0,    16'h3333));
    send_paced(mk_req(OP_WRITE_MULTI,  8'd2,   16'h0000, 16'd0,    16'h0000));
    send_paced(mk_req(OP_WRITE_MULTI,  8'd2,   16'h0000, 16'd124,  16'h0000));
    send_paced(mk_req(OP_WRITE_MULTI,  8'd2,   16'hFFFF, 16'd2,    16'h0000));
    send_paced(mk_req(OP_WRITE_MULTI,  8'd2,   16'hFFFF, 16'd1,    16'h5A5A));
    send_paced(mk_req(OP_WRITE_MULTI,  8'd255, 16'h0000, 16'd1,    16'h0000));
    send_paced(mk_req(OP_READ_HOLDING, 8'd0,   16'h0000, 16'd1,    16'h0000));
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: write_registers(8'd0,   8'd255, 7'd125, 7'd123);
        1: write_registers(8'd0,   8'd0,   7'd1,   7'd1);
        2: write_registers(8'd200, 8'd100, 7'd60,  7'd60);
        3: write_registers(8'd0,   8'd255, 7'd0,   7'd0);
        4: write_registers(8'd17,  8'd80,  7'd3,   7'd5);
        5: write_registers(8'($urandom), 8'($urandom),
                           7'($urandom_range(1, 125)), 7'($urandom_range(1, 123)));
        default: write_registers(MIN_SLAVE_RESET, MAX_SLAVE_RESET,
                                 READ_LIMIT_RESET, WRITE_LIMIT_RESET);
      endcase
      for (int start = items_sent; items_sent - start < PHASE_ITEMS; ) begin
        send_random_sequence();
        if ($urandom_range(0, 24) == 0) wait_idle();
      end
      close_run();
      wait_idle();
    end

    $display("Run covered %0d items over %0d register settings plus reset values:",
             items_sent, phases);
    $display("  %0d frames and %0d rejected requests, %0d bytes checked",
             sb.frames, sb.rejects, sb.bytes_checked);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d bytes still due", sb.mismatches, sb.pending());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
